// ===== rtl/otr_pkg.sv =====
package otr_pkg;

  // Ring depth is a power of two: slots are the low bits of the counters.
  localparam int RING_DEPTH = 256;
  localparam int MAX_DRAIN  = 64;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = 32;
  localparam int SEQ_W      = 64;
  localparam int LIM_W      = 7;
  localparam int PID_W      = 31;
  localparam int CODE_W     = 16;
  localparam int ARG_W      = 64;

  typedef enum logic [1:0] {
    KIND_EMIT    = 2'd0,
    KIND_DRAIN   = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] type_code;
    logic [CODE_W-1:0] subsystem;
    logic [PID_W-1:0]  pid;
    logic [ARG_W-1:0]  a;
    logic [ARG_W-1:0]  b;
    logic [ARG_W-1:0]  c;
    logic [ARG_W-1:0]  d;
  } event_t;

  typedef struct packed {
    kind_t            kind;
    logic [LIM_W-1:0] limit;
    event_t           ev;
  } cmd_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    event_t           ev;
  } entry_t;

  typedef struct packed {
    logic   has_event;
    entry_t ent;
    logic   pending;
    logic   last;
  } row_t;

  typedef struct packed {
    logic             enable;
    logic             draining;
    logic [CNT_W-1:0] unread;
  } status_t;

  typedef enum logic {
    B_IDLE  = 1'b0,
    B_DRAIN = 1'b1
  } back_state_t;

endpackage

// ===== rtl/overwrite_event_trace_ring.sv =====
// Channel   Direction  Handshake              Beat carries
// in        input      in_valid / in_ready    kind, event fields, max_count
// out       output     out_valid / out_ready  one result row
// cfg       input      cfg_valid / cfg_ready  enable bit on cfg_data
//
// Emit, discard and unused kinds give one row each, as does a drain that finds nothing.
// A drain of n events gives n rows, one per cycle while the output queue has room,
// paced by the single registered read port of the ring memory. Reset clears counters
// and the sequence number at once, with no memory sweep. A stalled output fills a
// two-row queue, then the back end and the two-entry command queue hold and in_ready
// drops.
module overwrite_event_trace_ring (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind,
  input  logic [otr_pkg::CODE_W-1:0] event_type,
  input  logic [otr_pkg::CODE_W-1:0] subsystem,
  input  logic [otr_pkg::PID_W-1:0]  owner_pid,
  input  logic [otr_pkg::ARG_W-1:0]  word_a,
  input  logic [otr_pkg::ARG_W-1:0]  word_b,
  input  logic [otr_pkg::ARG_W-1:0]  word_c,
  input  logic [otr_pkg::ARG_W-1:0]  word_d,
  input  logic [otr_pkg::LIM_W-1:0]  max_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       has_event,
  output logic [otr_pkg::SEQ_W-1:0]  seq_number,
  output logic [otr_pkg::CODE_W-1:0] out_type,
  output logic [otr_pkg::CODE_W-1:0] out_subsystem,
  output logic [otr_pkg::PID_W-1:0]  out_pid,
  output logic [otr_pkg::ARG_W-1:0]  out_a,
  output logic [otr_pkg::ARG_W-1:0]  out_b,
  output logic [otr_pkg::ARG_W-1:0]  out_c,
  output logic [otr_pkg::ARG_W-1:0]  out_d,
  output logic                       pending,
  output logic                       last
);

  logic             f_valid;
  logic             f_ready;
  otr_pkg::cmd_t    f_cmd;
  logic             q_valid;
  logic             q_ready;
  otr_pkg::cmd_t    q_cmd;
  otr_pkg::row_t    row;
  otr_pkg::status_t status;

  otr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .event_type (event_type),
    .subsystem  (subsystem),
    .owner_pid  (owner_pid),
    .word_a     (word_a),
    .word_b     (word_b),
    .word_c     (word_c),
    .word_d     (word_d),
    .max_count  (max_count),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  otr_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  otr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (row),
    .status    (status)
  );

  assign has_event     = row.has_event;
  assign seq_number    = row.ent.seq;
  assign out_type      = row.ent.ev.type_code;
  assign out_subsystem = row.ent.ev.subsystem;
  assign out_pid       = row.ent.ev.pid;
  assign out_a         = row.ent.ev.a;
  assign out_b         = row.ent.ev.b;
  assign out_c         = row.ent.ev.c;
  assign out_d         = row.ent.ev.d;
  assign pending       = row.pending;
  assign last          = row.last;

  a_unread_bound: assert property (@(posedge clk) disable iff (rst)
    status.unread <= otr_pkg::CNT_W'(otr_pkg::RING_DEPTH))
    else $error("unread count exceeds ring depth");

  a_pending_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && pending |-> status.enable)
    else $error("pending reported while disabled");

  a_ack_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> has_event)
    else $error("acknowledge row without last");

  a_drain_source: assert property (@(posedge clk) disable iff (rst)
    $rose(status.draining) |-> status.unread != '0)
    else $error("drain started on an empty ring");

endmodule

// ===== rtl/otr_front.sv =====
module otr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind,
  input  logic [otr_pkg::CODE_W-1:0] event_type,
  input  logic [otr_pkg::CODE_W-1:0] subsystem,
  input  logic [otr_pkg::PID_W-1:0]  owner_pid,
  input  logic [otr_pkg::ARG_W-1:0]  word_a,
  input  logic [otr_pkg::ARG_W-1:0]  word_b,
  input  logic [otr_pkg::ARG_W-1:0]  word_c,
  input  logic [otr_pkg::ARG_W-1:0]  word_d,
  input  logic [otr_pkg::LIM_W-1:0]  max_count,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output otr_pkg::cmd_t              cmd
);

  otr_pkg::cmd_t cmd_decoded;
  logic          take;

  assign in_ready  = !cmd_valid || cmd_ready;
  assign take      = in_valid && in_ready;

  always_comb begin
    cmd_decoded.kind         = otr_pkg::kind_t'(kind);
    cmd_decoded.ev.type_code = event_type;
    cmd_decoded.ev.subsystem = subsystem;
    cmd_decoded.ev.pid       = owner_pid;
    cmd_decoded.ev.a         = word_a;
    cmd_decoded.ev.b         = word_b;
    cmd_decoded.ev.c         = word_c;
    cmd_decoded.ev.d         = word_d;
    // clamp the drain length once here so the back end never sees excess
    if (max_count > otr_pkg::LIM_W'(otr_pkg::MAX_DRAIN)) begin
      cmd_decoded.limit = otr_pkg::LIM_W'(otr_pkg::MAX_DRAIN);
    end else begin
      cmd_decoded.limit = max_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_decoded;
    end
  end

endmodule

// ===== rtl/otr_cmd_queue.sv =====
module otr_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  otr_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output otr_pkg::cmd_t pop_cmd
);

  otr_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/otr_back.sv =====
module otr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  otr_pkg::cmd_t    cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output otr_pkg::row_t    out_row,
  output otr_pkg::status_t status
);

  otr_pkg::back_state_t state;
  otr_pkg::back_state_t state_next;

  logic                        enable;
  logic [otr_pkg::CNT_W-1:0]   write_count;
  logic [otr_pkg::CNT_W-1:0]   write_count_next;
  logic [otr_pkg::CNT_W-1:0]   read_count;
  logic [otr_pkg::CNT_W-1:0]   read_count_next;
  logic [otr_pkg::SEQ_W-1:0]   seq_counter;
  logic [otr_pkg::SEQ_W-1:0]   seq_counter_next;
  logic [otr_pkg::LIM_W-1:0]   remain;
  logic [otr_pkg::LIM_W-1:0]   remain_next;

  otr_pkg::entry_t             ring [otr_pkg::RING_DEPTH];
  otr_pkg::entry_t             rd_data;
  otr_pkg::entry_t             wr_data;
  logic                        wr_en;
  logic                        rd_en;

  logic                        stg_valid;
  logic                        stg_valid_next;
  logic                        stg_mem;
  logic                        stg_mem_next;
  logic                        stg_pending;
  logic                        stg_pending_next;
  logic                        stg_last;
  logic                        stg_last_next;

  otr_pkg::row_t               ofifo [2];
  otr_pkg::row_t               push_row;
  logic                        ohead;
  logic [1:0]                  ocount;
  logic [1:0]                  occupancy;
  logic                        pop;
  logic                        slot_free;

  logic [otr_pkg::CNT_W-1:0]   unread;
  logic [otr_pkg::CNT_W-1:0]   wc_inc;
  logic [otr_pkg::CNT_W-1:0]   rc_inc;
  logic [otr_pkg::LIM_W-1:0]   drain_n;
  logic                        start_drain;

  assign cfg_ready = 1'b1;

  assign unread  = write_count - read_count;
  assign wc_inc  = write_count + otr_pkg::CNT_W'(1);
  assign rc_inc  = read_count + otr_pkg::CNT_W'(1);
  assign drain_n = (unread < otr_pkg::CNT_W'(cmd.limit)) ? unread[otr_pkg::LIM_W-1:0]
                                                         : cmd.limit;
  assign start_drain = (cmd.kind == otr_pkg::KIND_DRAIN) && enable && (drain_n != '0);

  // A slot is free when the stage plus the output queue leave room for one more row.
  assign pop       = out_valid && out_ready;
  assign occupancy = ocount + {1'b0, stg_valid};
  assign slot_free = (occupancy < 2'd2) || pop;

  assign status.enable   = enable;
  assign status.draining = (state == otr_pkg::B_DRAIN);
  assign status.unread   = unread;

  always_comb begin
    state_next = state;
    case (state)
      otr_pkg::B_IDLE: begin
        if (cmd_valid && start_drain) begin
          state_next = otr_pkg::B_DRAIN;
        end
      end
      otr_pkg::B_DRAIN: begin
        if (slot_free && remain == otr_pkg::LIM_W'(1)) begin
          state_next = otr_pkg::B_IDLE;
        end
      end
      default: state_next = otr_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready        = 1'b0;
    write_count_next = write_count;
    read_count_next  = read_count;
    seq_counter_next = seq_counter;
    remain_next      = remain;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    stg_valid_next   = 1'b0;
    stg_mem_next     = 1'b0;
    stg_pending_next = 1'b0;
    stg_last_next    = 1'b0;
    case (state)
      otr_pkg::B_IDLE: begin
        if (cmd_valid) begin
          if (start_drain) begin
            cmd_ready   = 1'b1;
            remain_next = drain_n;
          end else if (slot_free) begin
            cmd_ready      = 1'b1;
            stg_valid_next = 1'b1;
            stg_last_next  = 1'b1;
            case (cmd.kind)
              otr_pkg::KIND_EMIT: begin
                if (enable) begin
                  wr_en            = 1'b1;
                  seq_counter_next = seq_counter + otr_pkg::SEQ_W'(1);
                  write_count_next = wc_inc;
                  // full ring: drop the oldest unread event
                  if ((wc_inc - read_count) > otr_pkg::CNT_W'(otr_pkg::RING_DEPTH)) begin
                    read_count_next = wc_inc - otr_pkg::CNT_W'(otr_pkg::RING_DEPTH);
                  end
                end
              end
              otr_pkg::KIND_DISCARD: begin
                read_count_next = write_count;
              end
              default: begin
              end
            endcase
            stg_pending_next = enable && (write_count_next != read_count_next);
          end
        end
      end
      otr_pkg::B_DRAIN: begin
        if (slot_free) begin
          rd_en            = 1'b1;
          stg_valid_next   = 1'b1;
          stg_mem_next     = 1'b1;
          read_count_next  = rc_inc;
          remain_next      = remain - otr_pkg::LIM_W'(1);
          stg_last_next    = (remain == otr_pkg::LIM_W'(1));
          stg_pending_next = enable && (rc_inc != write_count);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wr_data.seq = seq_counter_next;
    wr_data.ev  = cmd.ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= otr_pkg::B_IDLE;
      enable      <= 1'b1;
      write_count <= '0;
      read_count  <= '0;
      seq_counter <= '0;
      remain      <= '0;
      stg_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      write_count <= write_count_next;
      read_count  <= read_count_next;
      seq_counter <= seq_counter_next;
      remain      <= remain_next;
      stg_valid   <= stg_valid_next;
      if (cfg_valid) begin
        enable <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_mem     <= stg_mem_next;
    stg_pending <= stg_pending_next;
    stg_last    <= stg_last_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[write_count[otr_pkg::ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= ring[read_count[otr_pkg::ADDR_W-1:0]];
    end
  end

  // Acknowledge rows carry zero payload.
  always_comb begin
    push_row.has_event = stg_mem;
    push_row.ent       = stg_mem ? rd_data : '0;
    push_row.pending   = stg_pending;
    push_row.last      = stg_last;
  end

  assign out_valid = (ocount != 2'd0);
  assign out_row   = ofifo[ohead];

  always_ff @(posedge clk) begin
    if (rst) begin
      ohead  <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (pop) begin
        ohead <= !ohead;
      end
      ocount <= ocount + {1'b0, stg_valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (stg_valid) begin
      ofifo[ohead ^ ocount[0]] <= push_row;
    end
  end

endmodule

// ===== test/overwrite_event_trace_ring_test.sv =====
module overwrite_event_trace_ring_test;
  timeunit 1ns;
  timeprecision 1ps;

  import otr_pkg::*;

  localparam int SETTLE_CYCLES = 8;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    kind_t             kind;
    bit [CODE_W-1:0]   etype;
    bit [CODE_W-1:0]   subsys;
    bit [PID_W-1:0]    pid;
    bit [ARG_W-1:0]    wa;
    bit [ARG_W-1:0]    wb;
    bit [ARG_W-1:0]    wc;
    bit [ARG_W-1:0]    wd;
    bit [LIM_W-1:0]    limit;
  } trace_cmd_t;

  typedef struct {
    bit                has_event;
    bit [SEQ_W-1:0]    seq;
    bit [CODE_W-1:0]   etype;
    bit [CODE_W-1:0]   subsys;
    bit [PID_W-1:0]    pid;
    bit [ARG_W-1:0]    wa;
    bit [ARG_W-1:0]    wb;
    bit [ARG_W-1:0]    wc;
    bit [ARG_W-1:0]    wd;
    bit                pending;
    bit                last;
  } trace_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          kind = '0;
  logic [CODE_W-1:0]   event_type = '0;
  logic [CODE_W-1:0]   subsystem = '0;
  logic [PID_W-1:0]    owner_pid = '0;
  logic [ARG_W-1:0]    word_a = '0;
  logic [ARG_W-1:0]    word_b = '0;
  logic [ARG_W-1:0]    word_c = '0;
  logic [ARG_W-1:0]    word_d = '0;
  logic [LIM_W-1:0]    max_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                has_event;
  logic [SEQ_W-1:0]    seq_number;
  logic [CODE_W-1:0]   out_type;
  logic [CODE_W-1:0]   out_subsystem;
  logic [PID_W-1:0]    out_pid;
  logic [ARG_W-1:0]    out_a;
  logic [ARG_W-1:0]    out_b;
  logic [ARG_W-1:0]    out_c;
  logic [ARG_W-1:0]    out_d;
  logic                pending;
  logic                last;

  overwrite_event_trace_ring dut (.*);

  // Ring predictor state
  bit                  ring_on = 1'b1;
  bit [CNT_W-1:0]      ring_wr = '0;
  bit [CNT_W-1:0]      ring_rd = '0;
  bit [SEQ_W-1:0]      ring_seq = '0;
  trace_row_t          ring_mem [RING_DEPTH];
  trace_row_t          expected_rows [$];

  int unsigned         send_gap_pct = 0;
  int unsigned         out_stall_pct = 0;
  int unsigned         mismatches = 0;
  int unsigned         rows_seen = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("overwrite_event_trace_ring_test failed");
    $finish;
  end

  function automatic bit pending_now();
    return ring_on && (ring_wr != ring_rd);
  endfunction

  function automatic trace_row_t ack_row();
    trace_row_t r;
    r = '{default: '0};
    r.pending = pending_now();
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_rows(input trace_cmd_t c);
    trace_row_t r;
    bit [CNT_W-1:0] avail;
    int unsigned cap, n;
    case (c.kind)
      KIND_EMIT: begin
        if (ring_on) begin
          r = '{default: '0};
          ring_seq++;
          r.seq = ring_seq;
          r.etype = c.etype;
          r.subsys = c.subsys;
          r.pid = c.pid;
          r.wa = c.wa;
          r.wb = c.wb;
          r.wc = c.wc;
          r.wd = c.wd;
          ring_mem[ring_wr[ADDR_W-1:0]] = r;
          ring_wr++;
          // drop the oldest unread event on overflow
          if (ring_wr - ring_rd > CNT_W'(RING_DEPTH)) ring_rd = ring_wr - CNT_W'(RING_DEPTH);
        end
        expected_rows.push_back(ack_row());
      end
      KIND_DRAIN: begin
        cap = (c.limit > MAX_DRAIN) ? MAX_DRAIN : c.limit;
        avail = ring_wr - ring_rd;
        n = ring_on ? ((avail < cap) ? avail : cap) : 0;
        for (int i = 0; i < n; i++) begin
          r = ring_mem[ring_rd[ADDR_W-1:0]];
          ring_rd++;
          r.has_event = 1'b1;
          r.pending = pending_now();
          r.last = (i == n - 1);
          expected_rows.push_back(r);
        end
        if (n == 0) expected_rows.push_back(ack_row());
      end
      KIND_DISCARD: begin
        ring_rd = ring_wr;
        expected_rows.push_back(ack_row());
      end
      default: expected_rows.push_back(ack_row());
    endcase
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100) $display("row %0d: %s got %h, want %h", rows_seen, field, got, want);
  endtask

  always @(posedge clk) begin : row_check
    trace_row_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_rows.size() == 0) begin
          flag_mismatch("row with nothing expected", seq_number, '0);
        end else begin
          want = expected_rows.pop_front();
          if (has_event !== want.has_event) flag_mismatch("has_event", has_event, want.has_event);
          if (seq_number !== want.seq) flag_mismatch("seq_number", seq_number, want.seq);
          if (out_type !== want.etype) flag_mismatch("out_type", out_type, want.etype);
          if (out_subsystem !== want.subsys)
            flag_mismatch("out_subsystem", out_subsystem, want.subsys);
          if (out_pid !== want.pid) flag_mismatch("out_pid", out_pid, want.pid);
          if (out_a !== want.wa) flag_mismatch("out_a", out_a, want.wa);
          if (out_b !== want.wb) flag_mismatch("out_b", out_b, want.wb);
          if (out_c !== want.wc) flag_mismatch("out_c", out_c, want.wc);
          if (out_d !== want.wd) flag_mismatch("out_d", out_d, want.wd);
          if (pending !== want.pending) flag_mismatch("pending", pending, want.pending);
          if (last !== want.last) flag_mismatch("last", last, want.last);
        end
        rows_seen++;
      end
      out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  task automatic set_idling(input idle_mode_t m);
    send_gap_pct = (m == IDLE_SENDER) ? 66 : (m == IDLE_BOTH) ? 15 : 0;
    out_stall_pct = (m == IDLE_RECEIVER) ? 66 : (m == IDLE_BOTH) ? 15 : 0;
  endtask

  // Hold valid across back-to-back beats; lower it only for a gap.
  task automatic send_cmd(input trace_cmd_t c);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid   <= 1'b1;
    kind       <= c.kind;
    event_type <= c.etype;
    subsystem  <= c.subsys;
    owner_pid  <= c.pid;
    word_a     <= c.wa;
    word_b     <= c.wb;
    word_c     <= c.wc;
    word_d     <= c.wd;
    max_count  <= c.limit;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_rows(c);
  endtask

  task automatic wait_all_rows();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_rows.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input bit v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    ring_on = v;
  endtask

  function automatic trace_cmd_t random_cmd(input kind_t k, input bit [LIM_W-1:0] lim);
    trace_cmd_t c;
    c.kind = k;
    c.etype = CODE_W'($urandom);
    c.subsys = CODE_W'($urandom);
    c.pid = PID_W'($urandom);
    c.wa = {$urandom, $urandom};
    c.wb = {$urandom, $urandom};
    c.wc = {$urandom, $urandom};
    c.wd = {$urandom, $urandom};
    c.limit = lim;
    return c;
  endfunction

  function automatic trace_cmd_t pattern_emit(input bit [63:0] pat);
    trace_cmd_t c;
    c = random_cmd(KIND_EMIT, '0);
    c.etype = pat[CODE_W-1:0];
    c.subsys = pat[CODE_W-1:0];
    c.pid = pat[PID_W-1:0];
    c.wa = pat;
    c.wb = pat;
    c.wc = pat;
    c.wd = pat;
    return c;
  endfunction

  // Mostly emits and short drains so the ring keeps some depth.
  function automatic trace_cmd_t random_item();
    int unsigned pick, sel, lim;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    lim = (sel < 80) ? $urandom_range(0, 8) :
          (sel < 95) ? $urandom_range(9, 64) : $urandom_range(65, 127);
    if (pick < 55) return random_cmd(KIND_EMIT, LIM_W'(lim));
    if (pick < 88) return random_cmd(KIND_DRAIN, LIM_W'(lim));
    if (pick < 95) return random_cmd(KIND_DISCARD, LIM_W'(lim));
    return random_cmd(KIND_NOP, LIM_W'(lim));
  endfunction

  task automatic test_basic();
    set_idling(IDLE_NONE);
    write_enable(1'b1);
    send_cmd(random_cmd(KIND_DRAIN, 7'd5));
    send_cmd(pattern_emit('0));
    send_cmd(pattern_emit('1));
    send_cmd(pattern_emit({16{4'h5}}));
    send_cmd(pattern_emit({16{4'hA}}));
    send_cmd(random_cmd(KIND_DRAIN, 7'd0));
    send_cmd(random_cmd(KIND_DRAIN, 7'd1));
    send_cmd(random_cmd(KIND_NOP, 7'd3));
    send_cmd(random_cmd(KIND_DRAIN, 7'd127));
    repeat (3) send_cmd(random_cmd(KIND_EMIT, 7'd0));
    send_cmd(random_cmd(KIND_DISCARD, 7'd0));
    send_cmd(random_cmd(KIND_DRAIN, 7'd64));
    wait_all_rows();
  endtask

  task automatic test_disabled();
    set_idling(IDLE_NONE);
    repeat (2) send_cmd(random_cmd(KIND_EMIT, 7'd0));
    wait_all_rows();
    write_enable(1'b0);
    send_cmd(random_cmd(KIND_EMIT, 7'd0));
    send_cmd(random_cmd(KIND_DRAIN, 7'd64));
    wait_all_rows();
    write_enable(1'b1);
    // sequence numbers must not have advanced on the ignored emit
    send_cmd(random_cmd(KIND_DRAIN, 7'd1));
    wait_all_rows();
    write_enable(1'b0);
    send_cmd(random_cmd(KIND_DISCARD, 7'd0));
    wait_all_rows();
    write_enable(1'b1);
    send_cmd(random_cmd(KIND_DRAIN, 7'd64));
    send_cmd(random_cmd(KIND_EMIT, 7'd0));
    send_cmd(random_cmd(KIND_DRAIN, 7'd1));
    wait_all_rows();
  endtask

  task automatic test_overflow();
    set_idling(IDLE_BOTH);
    repeat (RING_DEPTH + 44) send_cmd(random_cmd(KIND_EMIT, LIM_W'($urandom)));
    send_cmd(random_cmd(KIND_DRAIN, 7'd127));
    send_cmd(random_cmd(KIND_DRAIN, 7'd64));
    send_cmd(random_cmd(KIND_DRAIN, 7'd100));
    send_cmd(random_cmd(KIND_DRAIN, 7'd65));
    send_cmd(random_cmd(KIND_DRAIN, 7'd64));
    wait_all_rows();
  endtask

  task automatic test_random();
    idle_mode_t m;
    for (int p = 0; p < 4; p++) begin
      m = idle_mode_t'(p);
      set_idling(m);
      for (int half = 0; half < 2; half++) begin
        for (int i = 0; i < 14; i++) send_cmd(random_item());
        // pause until every row is back, then write the enable bit
        wait_all_rows();
        write_enable((half == 0) ? (p != 2) : 1'b1);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic();
    test_disabled();
    test_overflow();
    test_random();
    wait_all_rows();
    if (mismatches == 0) begin
      $display("overwrite_event_trace_ring_test passed");
    end else begin
      $display("overwrite_event_trace_ring_test failed");
    end
    $finish;
  end

endmodule
